// ----- src/gre_chk_pkg.sv -----
// Shared types and constants for the GRE header checker.
// No dependencies; imported by gre_chk_verdict, gre_header_checker_unit and the testbench.
package gre_chk_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_REQUIRED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TUNNEL_KEY   = 1'd1;

    localparam int unsigned FLAG_CSUM_BIT = 7;
    localparam int unsigned FLAG_KEY_BIT  = 5;
    localparam int unsigned FLAG_SEQ_BIT  = 4;

    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] PROTO_IPV6 = 16'h86DD;
    localparam logic [15:0] PROTO_NHRP = 16'h2001;

    localparam logic [4:0] COUNT_MAX = 5'd31;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_VER    = 3'd2;
    localparam logic [2:0] ST_KEY_FLAG   = 3'd3;
    localparam logic [2:0] ST_KEY_VALUE  = 3'd4;
    localparam logic [2:0] ST_BAD_PROTO  = 3'd5;

    localparam logic [1:0] CLS_IPV4 = 2'd0;
    localparam logic [1:0] CLS_IPV6 = 2'd1;
    localparam logic [1:0] CLS_NHRP = 2'd2;

    typedef struct packed {
        logic [7:0]  flag_byte;
        logic [2:0]  version_bits;
        logic [15:0] protocol_word;
        logic [31:0] key_word;
        logic [4:0]  byte_count;
    } pkt_fields_t;

    typedef struct packed {
        logic       strip_header;
        logic [1:0] proto_class;
        logic [4:0] header_len;
        logic [2:0] status;
    } verdict_t;

endpackage

// ----- src/gre_chk_verdict.sv -----
// Verdict logic: status, header length, protocol class and strip flag from captured fields.
// Depends on gre_chk_pkg.
module gre_chk_verdict (
    input  gre_chk_pkg::pkt_fields_t fields,
    input  logic                     key_required,
    input  logic [31:0]              tunnel_key,
    output gre_chk_pkg::verdict_t    verdict
);
    import gre_chk_pkg::*;

    logic       csum;
    logic       kf;
    logic       sf;
    logic [4:0] hlen;
    logic [4:0] key_end;
    logic [4:0] len;

    assign csum    = fields.flag_byte[FLAG_CSUM_BIT];
    assign kf      = fields.flag_byte[FLAG_KEY_BIT];
    assign sf      = fields.flag_byte[FLAG_SEQ_BIT];
    assign len     = fields.byte_count;
    assign hlen    = 5'd4 + {2'b00, csum, 2'b00} + {2'b00, kf, 2'b00} + {2'b00, sf, 2'b00};
    assign key_end = csum ? 5'd12 : 5'd8;

    always_comb begin
        verdict.status       = ST_OK;
        verdict.header_len   = hlen;
        verdict.proto_class  = CLS_IPV4;
        verdict.strip_header = 1'b0;
        priority if (len < 5'd4) begin
            verdict.status = ST_TOO_SHORT;
        end else if (fields.version_bits != 3'd0) begin
            verdict.status = ST_BAD_VER;
        end else if (csum && len < 5'd8) begin
            verdict.status = ST_TOO_SHORT;
        end else if (kf != key_required) begin
            verdict.status = ST_KEY_FLAG;
        end else if (kf && len < key_end) begin
            verdict.status = ST_TOO_SHORT;
        end else if (kf && fields.key_word != tunnel_key) begin
            verdict.status = ST_KEY_VALUE;
        end else if (sf && len < hlen) begin
            verdict.status = ST_TOO_SHORT;
        end else if (fields.protocol_word == PROTO_IPV4) begin
            verdict.proto_class  = CLS_IPV4;
            verdict.strip_header = 1'b1;
        end else if (fields.protocol_word == PROTO_IPV6) begin
            verdict.proto_class  = CLS_IPV6;
            verdict.strip_header = 1'b1;
        end else if (fields.protocol_word == PROTO_NHRP) begin
            verdict.proto_class  = CLS_NHRP;
        end else begin
            verdict.status = ST_BAD_PROTO;
        end
    end

endmodule

// ----- src/gre_header_checker_unit.sv -----
// GRE receive header checker, top level: byte capture, config registers, result register.
// Depends on gre_chk_pkg and gre_chk_verdict.
//
//  channel | dir | payload                                          | handshake
//  s_      | in  | tdata[7:0] data_byte, tlast last_byte            | tvalid/tready
//  m_      | out | tdata status, header_len, proto_class, strip     | tvalid/tready
//  cfg_    | in  | cfg_index, cfg_wdata                             | cfg_we
//
// One byte per cycle while s_tready is high. The verdict for a packet appears on m_
// the cycle after its last byte transfer. Synchronous active-low reset clears config
// and packet state. s_tready drops only while a verdict waits and m_tready is low.
module gre_header_checker_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [2:0] status, [7:3] header_len,
                                                            // [9:8] proto_class,
                                                            // [10] strip_header, [15:11] 0
    input  logic                                 cfg_we,
    input  logic [gre_chk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gre_chk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import gre_chk_pkg::*;

    logic        key_required_reg;
    logic [31:0] tunnel_key_reg;

    pkt_fields_t fields_reg;
    pkt_fields_t fields_next;
    verdict_t    verdict;
    verdict_t    result_reg;
    logic        m_tvalid_reg;

    logic        accept;
    logic [4:0]  pos;
    logic [4:0]  key_off;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pos      = fields_reg.byte_count;

    always_comb begin
        fields_next = fields_reg;
        if (pos == 5'd0) begin
            fields_next.flag_byte = s_tdata;
        end
        if (pos == 5'd1) begin
            fields_next.version_bits = s_tdata[2:0];
        end
        if (pos == 5'd2) begin
            fields_next.protocol_word[15:8] = s_tdata;
        end
        if (pos == 5'd3) begin
            fields_next.protocol_word[7:0] = s_tdata;
        end
        key_off = fields_next.flag_byte[FLAG_CSUM_BIT] ? 5'd8 : 5'd4;
        if (pos >= key_off && pos < key_off + 5'd4) begin
            fields_next.key_word = {fields_reg.key_word[23:0], s_tdata};
        end
        if (pos < COUNT_MAX) begin
            fields_next.byte_count = pos + 5'd1;
        end
    end

    gre_chk_verdict u_verdict (
        .fields       (fields_next),
        .key_required (key_required_reg),
        .tunnel_key   (tunnel_key_reg),
        .verdict      (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_required_reg <= 1'b0;
            tunnel_key_reg   <= 32'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_REQUIRED: key_required_reg <= cfg_wdata[0];
                REG_TUNNEL_KEY:   tunnel_key_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fields_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                fields_reg <= '0;
            end else begin
                fields_reg <= fields_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept && s_tlast) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            result_reg <= verdict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, result_reg};

endmodule

// ----- tb/sv/tb_gre_header_checker_unit.sv -----
// Self-checking testbench for gre_header_checker_unit: streams GRE packets byte by byte,
// predicts each verdict in-bench and compares every result transfer field by field.
// Depends on gre_chk_pkg and the gre_header_checker_unit RTL.
module tb_gre_header_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gre_chk_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // in-bench copy of the checker state and registers
    logic                  cfg_key_required = 1'b0;
    logic [31:0]           cfg_tunnel_key = '0;
    logic [4:0]            hdr_count = '0;
    logic [7:0]            hdr_flags = '0;
    logic [2:0]            hdr_version = '0;
    logic [15:0]           hdr_proto = '0;
    logic [31:0]           hdr_key = '0;

    verdict_t              verdict_q[$];
    logic                  burst_mode = 1'b0;
    int                    errors = 0;
    int                    bytes_sent = 0;
    int                    packets_sent = 0;
    int                    verdicts_checked = 0;
    int                    key_settings = 0;
    int                    status_seen[8];
    int                    quiet_cycles = 0;

    gre_header_checker_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int idle_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Advance the header parser by one byte; queue a verdict on the last byte.
    function automatic void track_header_byte(input logic [7:0] b, input logic lst);
        int       pos;
        int       key_off;
        int       len;
        int       hlen;
        logic     csum;
        logic     kf;
        logic     sf;
        verdict_t v;
        pos = int'(hdr_count);
        case (pos)
            0: hdr_flags = b;
            1: hdr_version = b[2:0];
            2: hdr_proto[15:8] = b;
            3: hdr_proto[7:0] = b;
            default: ;
        endcase
        key_off = hdr_flags[FLAG_CSUM_BIT] ? 8 : 4;
        if (pos >= key_off && pos < key_off + 4)
            hdr_key = {hdr_key[23:0], b};
        if (hdr_count < COUNT_MAX)
            hdr_count = hdr_count + 5'd1;
        if (lst) begin
            len  = int'(hdr_count);
            csum = hdr_flags[FLAG_CSUM_BIT];
            kf   = hdr_flags[FLAG_KEY_BIT];
            sf   = hdr_flags[FLAG_SEQ_BIT];
            hlen = 4 + (csum ? 4 : 0) + (kf ? 4 : 0) + (sf ? 4 : 0);
            v = '0;
            v.header_len = hlen[4:0];
            if (len < 4)
                v.status = ST_TOO_SHORT;
            else if (hdr_version != 3'd0)
                v.status = ST_BAD_VER;
            else if (csum && len < 8)
                v.status = ST_TOO_SHORT;
            else if (kf != cfg_key_required)
                v.status = ST_KEY_FLAG;
            else if (kf && len < key_off + 4)
                v.status = ST_TOO_SHORT;
            else if (kf && hdr_key != cfg_tunnel_key)
                v.status = ST_KEY_VALUE;
            else if (sf && len < hlen)
                v.status = ST_TOO_SHORT;
            else if (hdr_proto == PROTO_IPV4) begin
                v.proto_class  = CLS_IPV4;
                v.strip_header = 1'b1;
            end else if (hdr_proto == PROTO_IPV6) begin
                v.proto_class  = CLS_IPV6;
                v.strip_header = 1'b1;
            end else if (hdr_proto == PROTO_NHRP) begin
                v.proto_class  = CLS_NHRP;
                v.strip_header = 1'b0;
            end else
                v.status = ST_BAD_PROTO;
            verdict_q.push_back(v);
            hdr_count   = '0;
            hdr_flags   = '0;
            hdr_version = '0;
            hdr_proto   = '0;
            hdr_key     = '0;
        end
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_header_byte(b, lst);
        bytes_sent++;
    endtask

    // Header laid out per the flags, padded with random payload, cut to total_len.
    task automatic send_gre(input logic [7:0] flags, input logic [7:0] ver_byte,
                            input logic [15:0] proto, input logic [31:0] key,
                            input int total_len);
        logic [7:0] pkt[$];
        int         i;
        pkt.push_back(flags);
        pkt.push_back(ver_byte);
        pkt.push_back(proto[15:8]);
        pkt.push_back(proto[7:0]);
        if (flags[FLAG_CSUM_BIT])
            repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        if (flags[FLAG_KEY_BIT])
            for (i = 3; i >= 0; i--) pkt.push_back(key[8*i +: 8]);
        if (flags[FLAG_SEQ_BIT])
            repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        while (pkt.size() < total_len)
            pkt.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < total_len; i++)
            send_byte(pkt[i], i == total_len - 1);
        packets_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_tunnel(input logic kr, input logic [31:0] key);
        logic [31:0] policy_word;
        drain_results();
        policy_word    = $urandom();
        policy_word[0] = kr;
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_REQUIRED;
        cfg_wdata <= policy_word;
        @(posedge aclk);
        cfg_key_required = kr;
        cfg_index <= REG_TUNNEL_KEY;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_tunnel_key = key;
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    task automatic send_random_packet();
        logic [7:0]  flags;
        logic [7:0]  ver_byte;
        logic [15:0] proto;
        logic [31:0] key;
        int          pick;
        int          hlen;
        int          total;
        int          i;
        if ($urandom_range(0, 9) == 0) begin
            total = $urandom_range(1, 8);
            for (i = 0; i < total; i++)
                send_byte(8'($urandom_range(0, 255)), i == total - 1);
            packets_sent++;
            return;
        end
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_KEY_BIT] = ($urandom_range(0, 9) == 0) ? !cfg_key_required
                                                           : cfg_key_required;
        ver_byte = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0)
            ver_byte[2:0] = 3'd0;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            proto = PROTO_IPV4;
        else if (pick < 6)
            proto = PROTO_IPV6;
        else if (pick < 9)
            proto = PROTO_NHRP;
        else
            proto = 16'($urandom_range(0, 65535));
        key = ($urandom_range(0, 9) == 0) ? 32'($urandom()) : cfg_tunnel_key;
        hlen = 4 + (flags[FLAG_CSUM_BIT] ? 4 : 0) + (flags[FLAG_KEY_BIT] ? 4 : 0)
                 + (flags[FLAG_SEQ_BIT] ? 4 : 0);
        total = hlen + $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0)
            total = $urandom_range(hlen + 16, 40);
        else if ($urandom_range(0, 11) == 0)
            total = $urandom_range(1, hlen - 1);
        send_gre(flags, ver_byte, proto, key, total);
    endtask

    task automatic test_short_packets();
        program_tunnel(1'b0, 32'h0000_0000);
        send_gre(8'h00, 8'h00, PROTO_IPV4, 32'h0, 1);
        send_gre(8'hB0, 8'h00, PROTO_IPV4, 32'h0, 3);
    endtask

    task automatic test_version();
        send_gre(8'h00, 8'h07, PROTO_IPV4, 32'h0, 4);
        send_gre(8'h00, 8'hF8, PROTO_IPV6, 32'h0, 4);
    endtask

    task automatic test_protocols();
        send_gre(8'h00, 8'h00, PROTO_IPV4, 32'h0, 4);
        send_gre(8'h00, 8'h00, PROTO_NHRP, 32'h0, 5);
        send_gre(8'h00, 8'h00, 16'hFFFF, 32'h0, 4);
    endtask

    task automatic test_key_policy();
        send_gre(8'h20, 8'h00, PROTO_IPV4, 32'h0, 8);
        program_tunnel(1'b1, 32'hA5C3_0F96);
        send_gre(8'h00, 8'h00, PROTO_IPV4, 32'h0, 4);
        send_gre(8'h20, 8'h00, PROTO_IPV6, 32'hA5C3_0F96, 8);
        send_gre(8'h20, 8'h00, PROTO_IPV6, 32'hA5C3_0F97, 8);
    endtask

    // checksum moves the key to offset 8; each optional word can be cut short
    task automatic test_option_lengths();
        send_gre(8'hA0, 8'h00, PROTO_IPV4, 32'hA5C3_0F96, 6);
        send_gre(8'hA0, 8'h00, PROTO_IPV4, 32'hA5C3_0F96, 10);
        send_gre(8'hB0, 8'h00, PROTO_IPV4, 32'hA5C3_0F96, 14);
        send_gre(8'hFF, 8'h00, PROTO_NHRP, 32'hA5C3_0F96, 16);
    endtask

    task automatic test_long_packet();
        send_gre(8'hB0, 8'h00, PROTO_IPV4, 32'hA5C3_0F96, 36);
    endtask

    task automatic test_random_traffic();
        logic [31:0] keys[5];
        logic        policies[5];
        int          p;
        int          phase_start;
        keys[0] = 32'h0000_0000; policies[0] = 1'b0;
        keys[1] = 32'hFFFF_FFFF; policies[1] = 1'b1;
        keys[2] = $urandom();    policies[2] = 1'b1;
        keys[3] = $urandom();    policies[3] = 1'b0;
        keys[4] = 32'h0000_0000; policies[4] = 1'b1;
        for (p = 0; p < 5; p++) begin
            program_tunnel(policies[p], keys[p]);
            phase_start = bytes_sent;
            while (bytes_sent < phase_start + 170) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                repeat (4) send_random_packet();
            end
            burst_mode = 1'b0;
        end
    endtask

    initial begin : result_ready
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : verdict_check
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = verdict_t'(m_tdata[10:0]);
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict, expected none actual 0x%0h", $time, m_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("header_len", want.header_len, got.header_len);
                check_field("proto_class", want.proto_class, got.proto_class);
                check_field("strip_header", want.strip_header, got.strip_header);
                status_seen[want.status]++;
                verdicts_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_gre_header_checker_unit: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_packets();
        test_version();
        test_protocols();
        test_key_policy();
        test_option_lengths();
        test_long_packet();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d packets (%0d bytes) under %0d key settings, %0d verdicts checked",
                 packets_sent, bytes_sent, key_settings, verdicts_checked);
        $display("Verdicts: ok %0d, short %0d, version %0d, key flag %0d, key %0d, proto %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_SHORT], status_seen[ST_BAD_VER],
                 status_seen[ST_KEY_FLAG], status_seen[ST_KEY_VALUE], status_seen[ST_BAD_PROTO]);
        if (errors == 0)
            $display("tb_gre_header_checker_unit: PASS");
        else
            $display("tb_gre_header_checker_unit: FAIL");
        $finish;
    end
endmodule
